@@ sv/stt_pkg.sv @@
// Shared types, constants and helpers for the source text tokenizer.
`default_nettype none
package stt_pkg;
   localparam int OFFSET_BITS = 16;
   localparam int KEYWORD_MAX_LEN = 6;
   localparam int WORD_BITS = 8 * KEYWORD_MAX_LEN;
   localparam int LEN_BITS = $clog2(KEYWORD_MAX_LEN + 2);
   localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
   localparam int MAX_RES = 4;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [5:0] K_EOF = 6'd0;
   localparam logic [5:0] K_LPAREN = 6'd1;
   localparam logic [5:0] K_RPAREN = 6'd2;
   localparam logic [5:0] K_LBRACE = 6'd3;
   localparam logic [5:0] K_RBRACE = 6'd4;
   localparam logic [5:0] K_COMMA = 6'd5;
   localparam logic [5:0] K_DOT = 6'd6;
   localparam logic [5:0] K_DOT_DOT = 6'd7;
   localparam logic [5:0] K_SEMI = 6'd8;
   localparam logic [5:0] K_SLASH = 6'd19;
   localparam logic [5:0] K_STRING = 6'd20;
   localparam logic [5:0] K_NUMBER = 6'd21;
   localparam logic [5:0] K_IDENT = 6'd22;
   localparam logic [5:0] K_KEYWORD0 = 6'd23;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
   localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

   typedef enum logic [11:0] {
      M_IDLE       = 12'b000000000001,
      M_OP         = 12'b000000000010,
      M_DOT        = 12'b000000000100,
      M_SLASH      = 12'b000000001000,
      M_LINE       = 12'b000000010000,
      M_BLOCK      = 12'b000000100000,
      M_BLOCK_STAR = 12'b000001000000,
      M_STRING     = 12'b000010000000,
      M_NUM_INT    = 12'b000100000000,
      M_NUM_DOT    = 12'b001000000000,
      M_NUM_FRAC   = 12'b010000000000,
      M_IDENT      = 12'b100000000000
   } mode_type;

   typedef struct packed {
      logic [5:0] token_kind;
      logic [OFFSET_BITS-1:0] token_start;
      logic [OFFSET_BITS-1:0] token_end;
      logic [1:0] error_code;
   } token_type;

   typedef struct packed {
      logic [2:0] count;
      token_type [MAX_RES-1:0] tok;
   } batch_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic [5:0] op_single(input logic [7:0] c);
      case (c)
         "|": return 6'd9;
         "!": return 6'd11;
         "=": return 6'd13;
         "<": return 6'd15;
         default: return 6'd17;
      endcase
   endfunction

   function automatic logic [5:0] word_kind(input logic [WORD_BITS-1:0] w,
                                            input logic [LEN_BITS-1:0] n);
      logic [5:0] k;
      k = K_IDENT;
      case (n)
         LEN_BITS'(2): begin
            if (w == WORD_BITS'("if")) k = K_KEYWORD0;
            if (w == WORD_BITS'("fn")) k = K_KEYWORD0 + 6'd4;
         end
         LEN_BITS'(3): if (w == WORD_BITS'("for")) k = K_KEYWORD0 + 6'd3;
         LEN_BITS'(4): begin
            if (w == WORD_BITS'("else")) k = K_KEYWORD0 + 6'd1;
            if (w == WORD_BITS'("elif")) k = K_KEYWORD0 + 6'd2;
            if (w == WORD_BITS'("this")) k = K_KEYWORD0 + 6'd5;
            if (w == WORD_BITS'("none")) k = K_KEYWORD0 + 6'd7;
            if (w == WORD_BITS'("true")) k = K_KEYWORD0 + 6'd10;
         end
         LEN_BITS'(5): begin
            if (w == WORD_BITS'("super")) k = K_KEYWORD0 + 6'd6;
            if (w == WORD_BITS'("class")) k = K_KEYWORD0 + 6'd9;
            if (w == WORD_BITS'("false")) k = K_KEYWORD0 + 6'd11;
         end
         LEN_BITS'(6): if (w == WORD_BITS'("return")) k = K_KEYWORD0 + 6'd8;
         default: k = K_IDENT;
      endcase
      return k;
   endfunction
endpackage
`default_nettype wire

@@ sv/source_text_tokenizer.sv @@
// Top level: tokenizer built from scanner, batch queue and emitter.
// A byte's tokens are registered in the batch queue and emitted from there.
// Throughput: one byte per cycle while the queue has room; the emitter gives
// one token per cycle while rsp_ready is high, a byte's tokens in turn.
// Queue of four batches decouples the scanner from the emitter.
// Reset: synchronous, clears scan state, queue pointers and emitter index.
`default_nettype none
module source_text_tokenizer (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic req_kind,
   input  wire logic [7:0] req_source_byte,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [5:0] rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_end,
   output logic [1:0] rsp_error_code,
   output logic rsp_last_of_run
);
   stt_pkg::batch_type fb, qb;
   stt_pkg::token_type tok;
   logic fv, fr, qv, qr;

   stt_scanner u_scan (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready),
      .in_kind(req_kind), .in_byte(req_source_byte),
      .batch_valid(fv), .batch_ready(fr), .batch(fb)
   );

   stt_queue u_queue (
      .clock(clock), .reset(reset),
      .wr_valid(fv), .wr_ready(fr), .wr_data(fb),
      .rd_valid(qv), .rd_ready(qr), .rd_data(qb)
   );

   stt_emitter u_emit (
      .clock(clock), .reset(reset),
      .batch_valid(qv), .batch_ready(qr), .batch(qb),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_tok(tok), .out_last(rsp_last_of_run)
   );

   assign rsp_token_kind = tok.token_kind;
   assign rsp_token_start = 16'(tok.token_start);
   assign rsp_token_end = 16'(tok.token_end);
   assign rsp_error_code = tok.error_code;
endmodule
`default_nettype wire

@@ sv/stt_scanner.sv @@
// Front end: scan state machine turning each byte or end request into a batch of tokens.
`default_nettype none
module stt_scanner (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic in_ready,
   input  wire logic in_kind,
   input  wire logic [7:0] in_byte,
   output logic batch_valid,
   input  wire logic batch_ready,
   output stt_pkg::batch_type batch
);
   localparam int OB = stt_pkg::OFFSET_BITS;
   localparam int WB = stt_pkg::WORD_BITS;
   localparam int LB = stt_pkg::LEN_BITS;

   stt_pkg::mode_type mode_ff, mode_in;
   logic [7:0] pend_ff, pend_in;
   logic [OB-1:0] begin_ff, begin_in, pos_ff, pos_in, dot_ff, dot_in;
   logic [WB-1:0] word_ff, word_in;
   logic [LB-1:0] len_ff, len_in;
   logic err_ff, err_in;
   stt_pkg::batch_type b;

   assign in_ready = batch_ready;
   assign batch_valid = in_valid && b.count != 3'd0;
   assign batch = b;

   always_comb begin
      logic [OB-1:0] p, np;
      logic [7:0] c;
      logic do_begin;
      p = pos_ff;
      np = (pos_ff == stt_pkg::OFF_MAX) ? pos_ff : pos_ff + OB'(1);
      c = in_byte;
      mode_in = mode_ff;
      pend_in = pend_ff;
      begin_in = begin_ff;
      pos_in = pos_ff;
      dot_in = dot_ff;
      word_in = word_ff;
      len_in = len_ff;
      err_in = err_ff;
      b = '0;
      do_begin = 1'b0;
      if (in_kind) begin
         if (!err_ff) begin
            unique case (mode_ff)
               stt_pkg::M_OP: begin
                  b.tok[0] = {stt_pkg::op_single(pend_ff), begin_ff, p, stt_pkg::ERR_NONE};
                  b.count = 3'd1;
               end
               stt_pkg::M_DOT: begin
                  b.tok[0] = {stt_pkg::K_DOT, begin_ff, p, stt_pkg::ERR_NONE};
                  b.count = 3'd1;
               end
               stt_pkg::M_SLASH: begin
                  b.tok[0] = {stt_pkg::K_SLASH, begin_ff, p, stt_pkg::ERR_NONE};
                  b.count = 3'd1;
               end
               stt_pkg::M_NUM_INT, stt_pkg::M_NUM_FRAC: begin
                  b.tok[0] = {stt_pkg::K_NUMBER, begin_ff, p, stt_pkg::ERR_NONE};
                  b.count = 3'd1;
               end
               stt_pkg::M_NUM_DOT: begin
                  b.tok[0] = {stt_pkg::K_NUMBER, begin_ff, dot_ff, stt_pkg::ERR_NONE};
                  b.tok[1] = {stt_pkg::K_DOT, dot_ff, p, stt_pkg::ERR_NONE};
                  b.count = 3'd2;
               end
               stt_pkg::M_IDENT: begin
                  b.tok[0] = {stt_pkg::word_kind(word_ff, len_ff), begin_ff, p,
                              stt_pkg::ERR_NONE};
                  b.count = 3'd1;
               end
               default: b.count = 3'd0;
            endcase
            if (mode_ff == stt_pkg::M_STRING) begin
               b.tok[0] = {stt_pkg::K_EOF, begin_ff, p, stt_pkg::ERR_UNTERMINATED};
               b.count = 3'd1;
            end else begin
               b.tok[b.count[1:0]] = {stt_pkg::K_EOF, p, p, stt_pkg::ERR_NONE};
               b.count = b.count + 3'd1;
            end
         end
         mode_in = stt_pkg::M_IDLE;
         pend_in = '0;
         begin_in = '0;
         pos_in = '0;
         dot_in = '0;
         word_in = '0;
         len_in = '0;
         err_in = 1'b0;
      end else if (!err_ff) begin
         pos_in = np;
         unique case (mode_ff)
            stt_pkg::M_OP: begin
               if (c == ((pend_ff == "|") ? 8'h7C : 8'h3D)) begin
                  b.tok[0] = {stt_pkg::op_single(pend_ff) + 6'd1, begin_ff, np,
                              stt_pkg::ERR_NONE};
                  b.count = 3'd1;
                  mode_in = stt_pkg::M_IDLE;
               end else begin
                  b.tok[0] = {stt_pkg::op_single(pend_ff), begin_ff, p, stt_pkg::ERR_NONE};
                  b.count = 3'd1;
                  do_begin = 1'b1;
               end
            end
            stt_pkg::M_NUM_DOT: begin
               if (stt_pkg::is_digit(c)) begin
                  mode_in = stt_pkg::M_NUM_FRAC;
               end else begin
                  b.tok[0] = {stt_pkg::K_NUMBER, begin_ff, dot_ff, stt_pkg::ERR_NONE};
                  begin_in = dot_ff;
                  if (c == ".") begin
                     b.tok[1] = {stt_pkg::K_DOT_DOT, dot_ff, np, stt_pkg::ERR_NONE};
                     b.count = 3'd2;
                     mode_in = stt_pkg::M_IDLE;
                  end else begin
                     b.tok[1] = {stt_pkg::K_DOT, dot_ff, p, stt_pkg::ERR_NONE};
                     b.count = 3'd2;
                     do_begin = 1'b1;
                  end
               end
            end
            stt_pkg::M_DOT: begin
               if (c == ".") begin
                  b.tok[0] = {stt_pkg::K_DOT_DOT, begin_ff, np, stt_pkg::ERR_NONE};
                  b.count = 3'd1;
                  mode_in = stt_pkg::M_IDLE;
               end else begin
                  if (!stt_pkg::is_digit(c)) begin
                     b.tok[0] = {stt_pkg::K_DOT, begin_ff, p, stt_pkg::ERR_NONE};
                     b.count = 3'd1;
                  end
                  do_begin = 1'b1;
               end
            end
            stt_pkg::M_SLASH: begin
               if (c == "/") mode_in = stt_pkg::M_LINE;
               else if (c == "*") mode_in = stt_pkg::M_BLOCK;
               else begin
                  b.tok[0] = {stt_pkg::K_SLASH, begin_ff, p, stt_pkg::ERR_NONE};
                  b.count = 3'd1;
                  do_begin = 1'b1;
               end
            end
            stt_pkg::M_LINE: if (c == 8'h0A) mode_in = stt_pkg::M_IDLE;
            stt_pkg::M_BLOCK: if (c == "*") mode_in = stt_pkg::M_BLOCK_STAR;
            stt_pkg::M_BLOCK_STAR: begin
               if (c == "/") mode_in = stt_pkg::M_IDLE;
               else if (c != "*") mode_in = stt_pkg::M_BLOCK;
            end
            stt_pkg::M_STRING: begin
               if (c == 8'h22) begin
                  b.tok[0] = {stt_pkg::K_STRING, begin_ff, np, stt_pkg::ERR_NONE};
                  b.count = 3'd1;
                  mode_in = stt_pkg::M_IDLE;
               end
            end
            stt_pkg::M_NUM_INT: begin
               if (stt_pkg::is_digit(c)) begin
               end else if (c == ".") begin
                  dot_in = p;
                  mode_in = stt_pkg::M_NUM_DOT;
               end else begin
                  b.tok[0] = {stt_pkg::K_NUMBER, begin_ff, p, stt_pkg::ERR_NONE};
                  b.count = 3'd1;
                  do_begin = 1'b1;
               end
            end
            stt_pkg::M_NUM_FRAC: begin
               if (!stt_pkg::is_digit(c) && c != ".") begin
                  b.tok[0] = {stt_pkg::K_NUMBER, begin_ff, p, stt_pkg::ERR_NONE};
                  b.count = 3'd1;
                  do_begin = 1'b1;
               end
            end
            stt_pkg::M_IDENT: begin
               if (stt_pkg::is_alpha(c) || stt_pkg::is_digit(c)) begin
                  if (len_ff < LB'(stt_pkg::KEYWORD_MAX_LEN)) begin
                     word_in = {word_ff[WB-9:0], c};
                     len_in = len_ff + LB'(1);
                  end else begin
                     len_in = LB'(stt_pkg::KEYWORD_MAX_LEN + 1);
                  end
               end else begin
                  b.tok[0] = {stt_pkg::word_kind(word_ff, len_ff), begin_ff, p,
                              stt_pkg::ERR_NONE};
                  b.count = 3'd1;
                  do_begin = 1'b1;
               end
            end
            default: do_begin = 1'b1;
         endcase
         if (do_begin) begin
            begin_in = p;
            mode_in = stt_pkg::M_IDLE;
            case (c)
               "(", ")", "{", "}", ",", ";": begin
                  case (c)
                     "(": b.tok[b.count[1:0]].token_kind = stt_pkg::K_LPAREN;
                     ")": b.tok[b.count[1:0]].token_kind = stt_pkg::K_RPAREN;
                     "{": b.tok[b.count[1:0]].token_kind = stt_pkg::K_LBRACE;
                     "}": b.tok[b.count[1:0]].token_kind = stt_pkg::K_RBRACE;
                     ",": b.tok[b.count[1:0]].token_kind = stt_pkg::K_COMMA;
                     default: b.tok[b.count[1:0]].token_kind = stt_pkg::K_SEMI;
                  endcase
                  b.tok[b.count[1:0]].token_start = p;
                  b.tok[b.count[1:0]].token_end = np;
                  b.tok[b.count[1:0]].error_code = stt_pkg::ERR_NONE;
                  b.count = b.count + 3'd1;
               end
               "|", "!", "=", "<", ">": begin
                  pend_in = c;
                  mode_in = stt_pkg::M_OP;
               end
               ".": mode_in = stt_pkg::M_DOT;
               "/": mode_in = stt_pkg::M_SLASH;
               " ", 8'h0D, 8'h09, 8'h0A: begin
               end
               8'h22: mode_in = stt_pkg::M_STRING;
               default: begin
                  if (stt_pkg::is_digit(c)) mode_in = stt_pkg::M_NUM_INT;
                  else if (stt_pkg::is_alpha(c)) begin
                     word_in = WB'(c);
                     len_in = LB'(1);
                     mode_in = stt_pkg::M_IDENT;
                  end else begin
                     b.tok[b.count[1:0]] = {stt_pkg::K_EOF, p, np, stt_pkg::ERR_UNEXPECTED};
                     b.count = b.count + 3'd1;
                     err_in = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= stt_pkg::M_IDLE;
         pend_ff <= '0;
         begin_ff <= '0;
         pos_ff <= '0;
         dot_ff <= '0;
         word_ff <= '0;
         len_ff <= '0;
         err_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         mode_ff <= mode_in;
         pend_ff <= pend_in;
         begin_ff <= begin_in;
         pos_ff <= pos_in;
         dot_ff <= dot_in;
         word_ff <= word_in;
         len_ff <= len_in;
         err_ff <= err_in;
      end
   end
endmodule
`default_nettype wire

@@ sv/stt_queue.sv @@
// Short batch queue between scanner and token emitter.
`default_nettype none
module stt_queue (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic wr_valid,
   output logic wr_ready,
   input  wire stt_pkg::batch_type wr_data,
   output logic rd_valid,
   input  wire logic rd_ready,
   output stt_pkg::batch_type rd_data
);
   localparam int AB = $clog2(stt_pkg::QUEUE_DEPTH);
   stt_pkg::batch_type mem_ff [stt_pkg::QUEUE_DEPTH];
   logic [AB-1:0] wp_ff, rp_ff;
   logic [AB:0] cnt_ff;
   logic wr, rd;

   assign wr_ready = cnt_ff != (AB+1)'(stt_pkg::QUEUE_DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_data = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + AB'(1);
         if (rd) rp_ff <= rp_ff + AB'(1);
         cnt_ff <= cnt_ff + (AB+1)'(wr) - (AB+1)'(rd);
      end
   end
endmodule
`default_nettype wire

@@ sv/stt_emitter.sv @@
// Back end: steps through a batch, presenting one token per transfer.
`default_nettype none
module stt_emitter (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic batch_valid,
   output logic batch_ready,
   input  wire stt_pkg::batch_type batch,
   output logic out_valid,
   input  wire logic out_ready,
   output stt_pkg::token_type out_tok,
   output logic out_last
);
   logic [1:0] idx_ff;
   logic last;

   assign out_valid = batch_valid;
   assign out_tok = batch.tok[idx_ff];
   assign last = (3'(idx_ff) + 3'd1) == batch.count;
   assign out_last = last;
   assign batch_ready = out_ready && last;

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else if (out_valid && out_ready) idx_ff <= last ? 2'd0 : idx_ff + 2'd1;
   end
endmodule
`default_nettype wire
